// ===== hdl/clni_pkg.sv =====
// Shared types, constants and the transfer table for the character LCD nibble interface.
package clni_pkg;

  // Defaults for the top-level parameters
  localparam int COLUMNS_DEF = 20;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Panel command bytes
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY  = 8'h0C;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [3:0] NIB_BUS_4BIT = 4'h2;

  // Address offset of odd rows
  localparam logic [7:0] ROW_ODD_OFS = 8'd64;

  // Wait times in microseconds
  localparam logic [5:0]  LEAD_CMD_US = 6'd40;
  localparam logic [5:0]  LEAD_NONE   = 6'd0;
  localparam logic [11:0] TRAIL_US    = 12'd200;
  localparam logic [11:0] TRAIL_LONG_US = 12'd2200;

  // Transfer index within one job
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] INIT_LAST = 4'd12;

  // Operation codes on the op port
  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_HOME   = 3'd2,
    OP_SETPOS = 3'd3,
    OP_WRITE  = 3'd4,
    OP_CURSOR = 3'd5,
    OP_BLINK  = 3'd6
  } op_t;

  // Kinds of work handed to the back end
  typedef enum logic [1:0] {
    JOB_INIT = 2'd0,
    JOB_CMD  = 2'd1,
    JOB_DATA = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic       long_wait;
  } job_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic [5:0]  lead;
    logic [11:0] trail;
    logic        last;
  } xfer_t;

  // Transfer number idx of a job
  function automatic xfer_t job_xfer(job_t job, logic [IDX_W-1:0] idx);
    logic [7:0] b;
    logic       hi;
    logic       lng;
    logic       lst;
    logic       rs;
    logic       bare;
    xfer_t      x;
    b    = job.data;
    hi   = (idx == '0);
    lng  = job.long_wait;
    lst  = (idx != '0);
    rs   = (job.kind == JOB_DATA);
    bare = 1'b0;
    if (job.kind == JOB_INIT) begin
      rs  = 1'b0;
      hi  = idx[0];
      lng = (idx == 4'd8) || (idx == INIT_LAST);
      lst = (idx == INIT_LAST);
      case (idx) inside
        4'd0: begin
          b    = {NIB_BUS_4BIT, 4'h0};
          hi   = 1'b1;
          bare = 1'b1;
        end
        [4'd1:4'd4]:   b = CMD_FUNC_SET;
        [4'd5:4'd6]:   b = CMD_DISPLAY;
        [4'd7:4'd8]:   b = CMD_CLEAR;
        [4'd9:4'd10]:  b = CMD_ENTRY;
        default:       b = CMD_HOME;
      endcase
    end
    x.nibble = hi ? b[7:4] : b[3:0];
    x.rs     = rs;
    x.lead   = (hi && !rs && !bare) ? LEAD_CMD_US : LEAD_NONE;
    x.trail  = (!hi && lng) ? TRAIL_LONG_US : TRAIL_US;
    x.last   = lst;
    return x;
  endfunction

endpackage

// ===== hdl/char_lcd_nibble_interface_core.sv =====
// Top level of the character LCD nibble interface: front end, job queue, sequencer.
//
//  channel   | handshake   | payload
//  ----------+-------------+--------------------------------------------------
//  operation | push / full | op, row, col, char_code, flag
//  transfer  | empty / pop | nibble, rs, lead_wait_us, trail_wait_us, last
//
// One transfer leaves per cycle while pop and the queue keep up; each operation
// yields two transfers for most, thirteen for init and none for a dropped
// character or unused op code. The sequencer's output register sets that pace;
// an operation's first transfer passes through the job queue and then the result
// register. Reset clears the cursor state, the queue and the result register.
// A stalled pop holds the sequencer; push keeps going until the queue fills.
module char_lcd_nibble_interface_core #(
  parameter int COLUMNS     = clni_pkg::COLUMNS_DEF,
  parameter int QUEUE_DEPTH = clni_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic [1:0]  row,
  input  logic [4:0]  col,
  input  logic [7:0]  char_code,
  input  logic        flag,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  nibble,
  output logic        rs,
  output logic [5:0]  lead_wait_us,
  output logic [11:0] trail_wait_us,
  output logic        last
);
  import clni_pkg::*;

  logic  accept;
  logic  fe_valid;
  job_t  fe_job;
  logic  q_valid;
  job_t  q_job;
  logic  q_pop;
  logic  out_valid;
  xfer_t out_xfer;

  assign accept = push && !full;

  clni_front #(.COLUMNS(COLUMNS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .row       (row),
    .col       (col),
    .char_code (char_code),
    .flag      (flag),
    .job_valid (fe_valid),
    .job       (fe_job)
  );

  clni_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fe_valid),
    .wr_job   (fe_job),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  clni_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_job),
    .job_done  (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_xfer  (out_xfer)
  );

  // Result ports
  assign empty         = !out_valid;
  assign nibble        = out_xfer.nibble;
  assign rs            = out_xfer.rs;
  assign lead_wait_us  = out_xfer.lead;
  assign trail_wait_us = out_xfer.trail;
  assign last          = out_xfer.last;

endmodule

// ===== hdl/clni_front.sv =====
// Front end: accepts operations, tracks cursor state, turns most into jobs.
module clni_front #(
  parameter int COLUMNS = clni_pkg::COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [2:0]        op,
  input  logic [1:0]        row,
  input  logic [4:0]        col,
  input  logic [7:0]        char_code,
  input  logic              flag,
  output logic              job_valid,
  output clni_pkg::job_t    job
);
  import clni_pkg::*;

  localparam int CB = $clog2(COLUMNS + 1);
  localparam int CW = (CB > 5) ? CB : 5;

  logic [CW-1:0] cursor_col;
  logic [CW-1:0] cursor_col_next;
  logic          cursor_shown;
  logic          cursor_shown_next;
  logic          blink_on;
  logic          blink_on_next;
  logic [7:0]    addr_sum;
  logic          has_job;

  // DDRAM address of the requested position, wraps at 7 bits
  assign addr_sum = 8'(col) + (row[1] ? 8'(COLUMNS) : 8'd0)
                  + (row[0] ? ROW_ODD_OFS : 8'd0);

  // Classify the operation
  always_comb begin
    cursor_col_next   = cursor_col;
    cursor_shown_next = cursor_shown;
    blink_on_next     = blink_on;
    has_job           = 1'b1;
    job.kind          = JOB_CMD;
    job.data          = char_code;
    job.long_wait     = 1'b0;
    unique case (op_t'(op))
      OP_INIT: begin
        job.kind          = JOB_INIT;
        cursor_col_next   = '0;
        cursor_shown_next = 1'b0;
        blink_on_next     = 1'b0;
      end
      OP_CLEAR: begin
        job.data        = CMD_CLEAR;
        job.long_wait   = 1'b1;
        cursor_col_next = '0;
      end
      OP_HOME: begin
        job.data        = CMD_HOME;
        job.long_wait   = 1'b1;
        cursor_col_next = '0;
      end
      OP_SETPOS: begin
        job.data        = CMD_SET_ADDR | {1'b0, addr_sum[6:0]};
        cursor_col_next = CW'(col);
      end
      OP_WRITE: begin
        job.kind = JOB_DATA;
        if (cursor_col < CW'(COLUMNS)) begin
          cursor_col_next = cursor_col + 1'b1;
        end else begin
          has_job = 1'b0;
        end
      end
      OP_CURSOR: begin
        cursor_shown_next = flag;
        job.data = CMD_DISPLAY | {6'd0, flag, blink_on};
      end
      OP_BLINK: begin
        blink_on_next = flag;
        job.data = CMD_DISPLAY | {6'd0, cursor_shown, flag};
      end
      default: has_job = 1'b0;
    endcase
  end

  assign job_valid = accept && has_job;

  // Cursor and mode flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col   <= '0;
      cursor_shown <= 1'b0;
      blink_on     <= 1'b0;
    end else if (accept) begin
      cursor_col   <= cursor_col_next;
      cursor_shown <= cursor_shown_next;
      blink_on     <= blink_on_next;
    end
  end

endmodule

// ===== hdl/clni_queue.sv =====
// Short job queue between the front end and the transfer sequencer.
module clni_queue #(
  parameter int DEPTH = clni_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  clni_pkg::job_t  wr_job,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output clni_pkg::job_t  rd_job
);
  import clni_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full     = (count == NW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = slots[rd_ptr];

  // Storage, written at the tail
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/clni_back.sv =====
// Back end: steps through the transfers of each job into the result register.
module clni_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  clni_pkg::job_t  job,
  output logic            job_done,
  input  logic            pop,
  output logic            out_valid,
  output clni_pkg::xfer_t out_xfer
);
  import clni_pkg::*;

  logic [IDX_W-1:0] idx;
  xfer_t            xfer;
  logic             load;

  assign xfer     = job_xfer(job, idx);
  assign load     = job_valid && (!out_valid || pop);
  assign job_done = load && xfer.last;

  // Transfer counter within the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= xfer.last ? '0 : idx + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_xfer <= xfer;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the character LCD nibble interface: random and directed operations, checked transfers.
module tb;
  import clni_pkg::*;

  // Op code the block leaves unused
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int          PANEL_WIDTH  = 20;
  localparam logic [5:0]  CMD_LEAD     = 6'd40;
  localparam logic [5:0]  NO_LEAD      = 6'd0;
  localparam logic [11:0] TRAIL_SHORT  = 12'd200;
  localparam logic [11:0] TRAIL_LONG   = 12'd2200;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic [5:0]  lead;
    logic [11:0] trail;
    logic        last;
  } lcd_xfer_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  op = '0;
  logic [1:0]  row = '0;
  logic [4:0]  col = '0;
  logic [7:0]  char_code = '0;
  logic        flag = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  nibble;
  logic        rs;
  logic [5:0]  lead_wait_us;
  logic [11:0] trail_wait_us;
  logic        last;

  // Predicted panel state
  logic [1:0]  lcd_row;
  logic [4:0]  lcd_col;
  logic        lcd_cursor_on;
  logic        lcd_blink_on;

  lcd_xfer_t   pending_xfers[$];
  int          errors = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_hold_left = 0;

  char_lcd_nibble_interface_core u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .row          (row),
    .col          (col),
    .char_code    (char_code),
    .flag         (flag),
    .empty        (empty),
    .pop          (pop),
    .nibble       (nibble),
    .rs           (rs),
    .lead_wait_us (lead_wait_us),
    .trail_wait_us(trail_wait_us),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predictor
  function automatic void add_xfer(logic [3:0] nib, logic sel, logic [5:0] lead,
                                   logic [11:0] trail);
    lcd_xfer_t x;
    x.nibble = nib;
    x.rs     = sel;
    x.lead   = lead;
    x.trail  = trail;
    x.last   = 1'b0;
    pending_xfers.push_back(x);
  endfunction

  function automatic void add_command(logic [7:0] cmd, logic slow);
    add_xfer(cmd[7:4], 1'b0, CMD_LEAD, TRAIL_SHORT);
    add_xfer(cmd[3:0], 1'b0, NO_LEAD, slow ? TRAIL_LONG : TRAIL_SHORT);
  endfunction

  function automatic logic [7:0] display_mode();
    return CMD_DISPLAY | {6'd0, lcd_cursor_on, lcd_blink_on};
  endfunction

  function automatic void predict_transfers(logic [2:0] o, logic [1:0] r, logic [4:0] c,
                                            logic [7:0] ch, logic f);
    int        start_count;
    int        addr;
    lcd_xfer_t tail;
    start_count = pending_xfers.size();
    case (o) inside
      OP_INIT: begin
        add_xfer(NIB_BUS_4BIT, 1'b0, NO_LEAD, TRAIL_SHORT);
        add_command(CMD_FUNC_SET, 1'b0);
        add_command(CMD_FUNC_SET, 1'b0);
        lcd_cursor_on = 1'b0;
        lcd_blink_on  = 1'b0;
        add_command(display_mode(), 1'b0);
        add_command(CMD_CLEAR, 1'b1);
        add_command(CMD_ENTRY, 1'b0);
        add_command(CMD_HOME, 1'b1);
        lcd_row = '0;
        lcd_col = '0;
      end
      OP_CLEAR, OP_HOME: begin
        add_command((o == OP_CLEAR) ? CMD_CLEAR : CMD_HOME, 1'b1);
        lcd_row = '0;
        lcd_col = '0;
      end
      OP_SETPOS: begin
        // odd rows sit 64 up, the lower pair follows the upper pair's columns
        addr = int'(c) + PANEL_WIDTH * int'(r[1]) + 64 * int'(r[0]);
        lcd_row = r;
        lcd_col = c;
        add_command(CMD_SET_ADDR | {1'b0, 7'(addr)}, 1'b0);
      end
      OP_WRITE: begin
        // past the last column the character is dropped
        if (lcd_col < PANEL_WIDTH) begin
          add_xfer(ch[7:4], 1'b1, NO_LEAD, TRAIL_SHORT);
          add_xfer(ch[3:0], 1'b1, NO_LEAD, TRAIL_SHORT);
          lcd_col = lcd_col + 5'd1;
        end
      end
      OP_CURSOR: begin
        lcd_cursor_on = f;
        add_command(display_mode(), 1'b0);
      end
      OP_BLINK: begin
        lcd_blink_on = f;
        add_command(display_mode(), 1'b0);
      end
      default: ;
    endcase
    if (pending_xfers.size() > start_count) begin
      tail = pending_xfers[pending_xfers.size() - 1];
      tail.last = 1'b1;
      pending_xfers[pending_xfers.size() - 1] = tail;
    end
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  // Send one item, with an optional idle burst in front
  task automatic send_op(input logic [2:0] o, input logic [1:0] r, input logic [4:0] c,
                         input logic [7:0] ch, input logic f);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    op        <= o;
    row       <= r;
    col       <= c;
    char_code <= ch;
    flag      <= f;
    do @(posedge clk); while (full);
    predict_transfers(o, r, c, ch, f);
  endtask

  // Mostly writes and moves, a few of everything else
  task automatic send_random();
    int         pick;
    logic [2:0] o;
    logic [4:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 3)       o = OP_INIT;
    else if (pick < 6)  o = OP_CLEAR;
    else if (pick < 9)  o = OP_HOME;
    else if (pick < 30) o = OP_SETPOS;
    else if (pick < 80) o = OP_WRITE;
    else if (pick < 88) o = OP_CURSOR;
    else if (pick < 96) o = OP_BLINK;
    else                o = OP_UNUSED;
    if ($urandom_range(0, 4) == 0) c = 5'($urandom_range(20, 31));
    else                           c = 5'($urandom_range(0, 19));
    send_op(o, 2'($urandom), c, 8'($urandom), 1'($urandom));
  endtask

  // Stop sending and let every expected transfer come out
  task automatic wait_drained();
    int n;
    n = 0;
    push <= 1'b0;
    while (pending_xfers.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_xfers.size() != 0) begin
      $display("%0t: %0d transfers never arrived", $time, pending_xfers.size());
      errors++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    send_op(OP_INIT,   2'd0, 5'd0,  8'h00, 1'b0);
    send_op(OP_WRITE,  2'd0, 5'd0,  8'h00, 1'b0);
    send_op(OP_WRITE,  2'd3, 5'd31, 8'hFF, 1'b1);
    send_op(OP_SETPOS, 2'd1, 5'd0,  8'h00, 1'b0);
    send_op(OP_SETPOS, 2'd2, 5'd19, 8'h00, 1'b0);
    send_op(OP_WRITE,  2'd0, 5'd0,  8'h5A, 1'b0);
    // column now at the end: this one is dropped
    send_op(OP_WRITE,  2'd0, 5'd0,  8'hA5, 1'b0);
    send_op(OP_SETPOS, 2'd3, 5'd31, 8'h00, 1'b0);
    send_op(OP_WRITE,  2'd0, 5'd0,  8'h3C, 1'b0);
    send_op(OP_SETPOS, 2'd0, 5'd20, 8'h00, 1'b0);
    send_op(OP_CURSOR, 2'd0, 5'd0,  8'h00, 1'b1);
    send_op(OP_BLINK,  2'd0, 5'd0,  8'h00, 1'b1);
    send_op(OP_CURSOR, 2'd0, 5'd0,  8'h00, 1'b0);
    send_op(OP_BLINK,  2'd0, 5'd0,  8'h00, 1'b0);
    send_op(OP_CLEAR,  2'd3, 5'd31, 8'hFF, 1'b1);
    send_op(OP_WRITE,  2'd0, 5'd0,  8'h81, 1'b0);
    send_op(OP_HOME,   2'd3, 5'd31, 8'hFF, 1'b1);
    send_op(OP_UNUSED, 2'd3, 5'd31, 8'hFF, 1'b1);
    send_op(OP_CURSOR, 2'd0, 5'd0,  8'h00, 1'b1);
    send_op(OP_BLINK,  2'd0, 5'd0,  8'h00, 1'b1);
    // init has to turn both flags back off
    send_op(OP_INIT,   2'd3, 5'd31, 8'hFF, 1'b1);
    send_op(OP_BLINK,  2'd0, 5'd0,  8'h00, 1'b1);
    wait_drained();
  endtask

  // Receiver holds off long enough for the queue to fill and stall the sender
  task automatic test_backpressure();
    tx_idle_on   = 1'b0;
    rx_hold_left = 300;
    repeat (40) send_random();
    tx_idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random();
    repeat (330) send_random();
  endtask

  // Sender pauses until everything is out, then resumes
  task automatic test_sender_pause();
    repeat (6) send_random();
    wait_drained();
    repeat (6) send_random();
  endtask

  // Last stretch without idling on either side
  task automatic test_steady_stream();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (40) send_random();
  endtask

  // Stimulus
  initial begin
    lcd_row       = '0;
    lcd_col       = '0;
    lcd_cursor_on = 1'b0;
    lcd_blink_on  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    test_sender_pause();
    test_steady_stream();
    wait_drained();
    if (errors == 0) begin
      $display("** char_lcd_nibble_interface_core: PASSED **");
    end else begin
      $display("** char_lcd_nibble_interface_core: FAILED **");
    end
    $finish;
  end

  // Transfer checker and pop driver
  initial begin : transfer_checker
    int        stall_left;
    lcd_xfer_t want;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (pending_xfers.size() == 0) begin
          $display("%0t: unexpected transfer nibble=%0h rs=%0d lead=%0d trail=%0d last=%0d",
                   $time, nibble, rs, lead_wait_us, trail_wait_us, last);
          errors++;
        end else begin
          want = pending_xfers.pop_front();
          check_field("nibble", want.nibble, nibble);
          check_field("rs", want.rs, rs);
          check_field("lead_wait_us", want.lead, lead_wait_us);
          check_field("trail_wait_us", want.trail, trail_wait_us);
          check_field("last", want.last, last);
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("** char_lcd_nibble_interface_core: FAILED **");
    $finish;
  end

endmodule
